// ===== sv/bfe_pkg.sv =====
// Package for the bloom filter engine: sizes, action codes, hash constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bfe_pkg;
    localparam int StoreBitsDefault = 65536;
    localparam int MaxHashesDefault = 16;
    localparam int FilterBitsW = 17;
    localparam int HashCountW = 5;
    localparam int LoadIndexW = 13;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_LOAD  = 2'd3
    } action_t;

    localparam logic CFG_FILTER_BITS = 1'b0;
    localparam logic CFG_HASH_COUNT  = 1'b1;

    localparam logic [31:0] PR1 = 32'd2654435761;
    localparam logic [31:0] PR2 = 32'd2246822519;
    localparam logic [31:0] PR3 = 32'd3266489917;
    localparam logic [31:0] PR4 = 32'd668265263;
    localparam logic [31:0] PR5 = 32'd374761393;

    // Request and answer between the hash unit and the store controller
    typedef struct packed {
        logic        start;
        logic [63:0] key;
        logic [3:0]  len;
        logic [31:0] seed;
    } hash_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } hash_rsp_t;
endpackage
`default_nettype wire

// ===== sv/bfe_hash.sv =====
// Iterative XXH32 unit for keys of up to 8 bytes.
// Depends on bfe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bfe_hash
    import bfe_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire hash_req_t req,
    output hash_rsp_t      rsp
);
    typedef enum logic [2:0] {
        H_IDLE, H_WORD_ADD, H_WORD_ROT, H_BYTE_ADD, H_BYTE_ROT,
        H_FIN1, H_FIN2, H_FIN3
    } hstate_t;

    hstate_t     state_reg;
    logic [31:0] h_reg;
    logic [31:0] prod_reg;
    logic [63:0] key_reg;
    logic [3:0]  left_reg;
    logic        done_reg;

    logic [31:0] rot17, rot11, fin_a, fin_b;
    assign rot17 = {h_reg[14:0], h_reg[31:15]};
    assign rot11 = {h_reg[20:0], h_reg[31:21]};
    assign fin_a = h_reg ^ {15'd0, h_reg[31:15]};
    assign fin_b = h_reg ^ {13'd0, h_reg[31:13]};

    assign rsp.done  = done_reg;
    assign rsp.value = h_reg;

    // Advance the hash: each state does at most two 32x32 multiplies
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                H_IDLE: begin
                    if (req.start) begin
                        h_reg    <= req.seed + PR5 + {28'd0, req.len};
                        key_reg  <= req.key;
                        left_reg <= req.len;
                        if (req.len >= 4'd4) begin
                            prod_reg  <= req.key[31:0] * PR3;
                            state_reg <= H_WORD_ADD;
                        end else begin
                            prod_reg  <= {24'd0, req.key[7:0]} * PR5;
                            state_reg <= (req.len != 4'd0) ? H_BYTE_ADD : H_FIN1;
                        end
                    end
                end
                H_WORD_ADD: begin
                    h_reg     <= h_reg + prod_reg;
                    key_reg   <= {32'd0, key_reg[63:32]};
                    left_reg  <= left_reg - 4'd4;
                    state_reg <= H_WORD_ROT;
                end
                H_WORD_ROT: begin
                    h_reg <= rot17 * PR4;
                    if (left_reg >= 4'd4) begin
                        prod_reg  <= key_reg[31:0] * PR3;
                        state_reg <= H_WORD_ADD;
                    end else begin
                        prod_reg  <= {24'd0, key_reg[7:0]} * PR5;
                        state_reg <= (left_reg != 4'd0) ? H_BYTE_ADD : H_FIN1;
                    end
                end
                H_BYTE_ADD: begin
                    h_reg     <= h_reg + prod_reg;
                    key_reg   <= {8'd0, key_reg[63:8]};
                    left_reg  <= left_reg - 4'd1;
                    state_reg <= H_BYTE_ROT;
                end
                H_BYTE_ROT: begin
                    h_reg     <= rot11 * PR1;
                    prod_reg  <= {24'd0, key_reg[7:0]} * PR5;
                    state_reg <= (left_reg != 4'd0) ? H_BYTE_ADD : H_FIN1;
                end
                H_FIN1: begin
                    h_reg     <= fin_a * PR2;
                    state_reg <= H_FIN2;
                end
                H_FIN2: begin
                    h_reg     <= fin_b * PR3;
                    state_reg <= H_FIN3;
                end
                H_FIN3: begin
                    h_reg     <= h_reg ^ {16'd0, h_reg[31:16]};
                    done_reg  <= 1'b1;
                    state_reg <= H_IDLE;
                end
                default: state_reg <= H_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/bfe_mod.sv =====
// Restoring remainder unit: hash value modulo the filter size, one bit a cycle.
// Depends on bfe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bfe_mod
    import bfe_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [31:0]            dividend,
    input  wire logic [FilterBitsW-1:0] divisor,
    output logic                        done,
    output logic [FilterBitsW-1:0]      remainder
);
    logic [31:0]            num_reg;
    logic [FilterBitsW:0]   rem_reg;
    logic [FilterBitsW-1:0] div_reg;
    logic [5:0]             cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [FilterBitsW+1:0] trial;
    logic [FilterBitsW+1:0] shifted;

    assign shifted   = {rem_reg, num_reg[31]};
    assign trial     = shifted - {2'd0, div_reg};
    assign done      = done_reg;
    assign remainder = rem_reg[FilterBitsW-1:0];

    // Shift in one dividend bit, subtract when it fits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                num_reg  <= dividend;
                div_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= 6'd32;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= trial[FilterBitsW+1] ? shifted[FilterBitsW:0]
                                                 : trial[FilterBitsW:0];
                num_reg  <= {num_reg[30:0], 1'b0};
                cnt_reg  <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/bloom_filter_engine_unit.sv =====
// Bloom filter engine: XXH32 probes into a one-port byte store.
// Add/query: per probe a hash by key length, a remainder, then a store read and a read-modify-write.
// Clear: one store byte a cycle over ceil(filter_bits/8) bytes. Load: written as the request is taken.
// One transaction in flight; result held in an output register.
// aresetn (synchronous) resets registers, then a clearing pass over all store bytes
// zeroes the store before the first transaction is taken.
`timescale 1ns / 1ps
`default_nettype none
module bloom_filter_engine_unit
    import bfe_pkg::*;
#(
    parameter int STORE_BITS = StoreBitsDefault,
    parameter int MAX_HASHES = MaxHashesDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: action[1:0], key[65:2], key_length[69:66], load_index[82:70],
    // load_byte[90:83], zero fill to 96
    input  wire logic [95:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: hit[0], zero fill
    output logic [7:0]       m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int Bytes = (STORE_BITS + 7) / 8;
    localparam int AW = $clog2(Bytes);
    localparam int CW = $clog2(Bytes + 1);
    localparam int NW = $clog2(MAX_HASHES + 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_HASH, S_MOD, S_RD, S_RMW, S_CLR, S_OUT
    } state_t;

    logic [7:0]             mem [Bytes];
    logic [7:0]             rd_reg;
    state_t                 state_reg;
    logic [FilterBitsW-1:0] fbits_reg;
    logic [HashCountW-1:0]  hcnt_reg;
    logic [1:0]             act_reg;
    logic [63:0]            key_reg;
    logic [3:0]             len_reg;
    logic [NW-1:0]          seed_reg;
    logic [NW-1:0]          nh_reg;
    logic [FilterBitsW-1:0] bit_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   hit_reg;
    logic                   outv_reg;
    hash_req_t              hreq;
    hash_rsp_t              hrsp;
    logic                   mdone;
    logic [FilterBitsW-1:0] mrem;
    logic [FilterBitsW-1:0] fmod;
    logic [3:0]             len_in;
    logic [NW-1:0]          nh_in;
    logic [CW-1:0]          clr_n;
    logic [16:0]            clr_w;
    logic [7:0]             mask;
    logic [AW-1:0]          baddr;
    logic                   bin;
    logic                   we;
    logic [AW-1:0]          waddr;
    logic [7:0]             wdata;
    logic [12:0]            lidx;

    // Effective modulus and probe count
    always_comb begin
        fmod = fbits_reg;
        if (fbits_reg == '0) fmod = 17'd1;
        if ({15'd0, fbits_reg} > STORE_BITS) fmod = FilterBitsW'(STORE_BITS);
        len_in = (s_tdata[69:66] > 4'd8) ? 4'd8 : s_tdata[69:66];
        nh_in  = ({27'd0, hcnt_reg} > MAX_HASHES) ? NW'(MAX_HASHES)
                                                  : NW'(hcnt_reg);
        clr_w  = {3'd0, fmod[FilterBitsW-1:3]} + {16'd0, (fmod[2:0] != 3'd0)};
        clr_n  = ({15'd0, clr_w} > Bytes) ? CW'(Bytes) : CW'(clr_w);
        mask   = 8'd1 << bit_reg[2:0];
        baddr  = AW'(bit_reg >> 3);
        bin    = ({15'd0, bit_reg >> 3} < Bytes);
        lidx   = s_tdata[82:70];
    end

    assign hreq.key  = key_reg;
    assign hreq.len  = len_reg;
    assign hreq.seed = 32'(seed_reg);

    bfe_hash u_hash (.aclk(aclk), .aresetn(aresetn), .req(hreq), .rsp(hrsp));

    bfe_mod u_mod (
        .aclk(aclk), .aresetn(aresetn), .start(hrsp.done), .dividend(hrsp.value),
        .divisor(fmod), .done(mdone), .remainder(mrem)
    );

    logic hreq_start_reg;
    assign hreq.start = hreq_start_reg;

    assign s_tready  = (state_reg == S_IDLE) && !outv_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = outv_reg;
    assign m_tdata   = {7'd0, hit_reg};

    // Store write port decode
    always_comb begin
        we    = 1'b0;
        waddr = AW'(cnt_reg);
        wdata = '0;
        case (state_reg)
            S_INIT, S_CLR: we = (cnt_reg != '0);
            S_RMW: begin
                we    = (act_reg == ACT_ADD) && bin && ((rd_reg & mask) == 8'd0);
                waddr = baddr;
                wdata = rd_reg | mask;
            end
            S_IDLE: begin
                we    = s_tvalid && s_tready && (s_tdata[1:0] == ACT_LOAD)
                        && ({19'd0, lidx} < Bytes);
                waddr = AW'(lidx);
                wdata = s_tdata[90:83];
            end
            default: we = 1'b0;
        endcase
        if ((state_reg == S_INIT || state_reg == S_CLR) && cnt_reg != '0)
            waddr = AW'(cnt_reg - CW'(1));
    end

    // Single-port store: one read or one write a cycle
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        else    rd_reg <= mem[baddr];
    end

    // Sequencer: reset clearing pass, config writes, clear, and per probe hash, reduce, read, modify, write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_INIT;
            cnt_reg        <= CW'(Bytes);
            fbits_reg      <= 17'd65536;
            hcnt_reg       <= 5'd7;
            outv_reg       <= 1'b0;
            hreq_start_reg <= 1'b0;
        end else begin
            hreq_start_reg <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index[0] == CFG_FILTER_BITS) fbits_reg <= cfg_data[16:0];
                else                                 hcnt_reg  <= cfg_data[4:0];
            end
            if (m_tvalid && m_tready) outv_reg <= 1'b0;
            case (state_reg)
                S_INIT: begin
                    if (cnt_reg == '0) state_reg <= S_IDLE;
                    else cnt_reg <= cnt_reg - CW'(1);
                end
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        act_reg  <= s_tdata[1:0];
                        key_reg  <= s_tdata[65:2];
                        len_reg  <= len_in;
                        seed_reg <= '0;
                        nh_reg   <= nh_in;
                        hit_reg  <= (s_tdata[1:0] == ACT_QUERY);
                        case (s_tdata[1:0])
                            ACT_ADD, ACT_QUERY: begin
                                state_reg      <= (nh_in == '0) ? S_OUT : S_HASH;
                                hreq_start_reg <= (nh_in != '0);
                            end
                            ACT_CLEAR: begin
                                cnt_reg   <= clr_n;
                                state_reg <= S_CLR;
                            end
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_HASH: if (hrsp.done) state_reg <= S_MOD;
                S_MOD: begin
                    if (mdone) begin
                        bit_reg   <= mrem;
                        state_reg <= S_RD;
                    end
                end
                S_RD: state_reg <= S_RMW;
                S_RMW: begin
                    if (act_reg == ACT_ADD) begin
                        if (bin && ((rd_reg & mask) == 8'd0)) hit_reg <= 1'b1;
                    end else if (!bin || ((rd_reg & mask) == 8'd0)) begin
                        hit_reg <= 1'b0;
                    end
                    seed_reg <= seed_reg + NW'(1);
                    if (seed_reg + NW'(1) == nh_reg) state_reg <= S_OUT;
                    else if (act_reg == ACT_QUERY && (!bin || (rd_reg & mask) == 8'd0))
                        state_reg <= S_OUT;
                    else begin
                        state_reg      <= S_HASH;
                        hreq_start_reg <= 1'b1;
                    end
                end
                S_CLR: begin
                    if (cnt_reg == '0) state_reg <= S_OUT;
                    else cnt_reg <= cnt_reg - CW'(1);
                end
                S_OUT: begin
                    outv_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // No transaction taken during the clearing pass
    a_no_accept_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INIT) |-> !s_tready) else $error("accept during init");
    // Hash and remainder never finish together
    a_hash_mod_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(hrsp.done && mdone)) else $error("hash and mod overlap");
    // Result raises only from the output state
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT)) else $error("stray result");
`endif
endmodule
`default_nettype wire
